// File: hw/rtl/radix_digit_converter_unit_defines.svh
// assertion macros shared by the converter checker
`ifndef RADIX_DIGIT_CONVERTER_UNIT_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define RDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rdc_pkg.sv
// types, constants and helper functions of the radix digit converter
package rdc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;

    // quotient bits resolved per divider cycle
    localparam int DIV_BITS = 8;

    localparam logic [7:0] BASE_MIN = 8'd2;
    localparam logic [7:0] BASE_MAX = 8'd16;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [4:0] DIGIT_NONE = 5'd16;

    localparam logic [7:0] DIGIT_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
        logic [7:0] base;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] digit_char;
        logic       accepted;
        logic       last_res;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FETCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_digit;
        logic start_read;
        logic div_step;
        logic emit_status;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic in_is_read;
        logic in_last;
        logic in_base_ok;
        logic div_last_step;
        logic div_done;
        logic idx_zero;
        logic out_ready;
    } t_stat;

    function automatic logic [4:0] char_to_digit(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

endpackage

// File: hw/rtl/rdc_ctrl.sv
// controller state machine of the radix digit converter
module rdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rdc_pkg::t_stat i_stat,
    output rdc_pkg::t_cmd  o_cmd
);
    import rdc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_stat.out_ready;
                if (i_in_valid && i_stat.out_ready) begin
                    if (!i_stat.in_is_read) begin
                        o_cmd.load_digit  = 1'b1;
                        o_cmd.emit_status = i_stat.in_last;
                    end else if (i_stat.in_base_ok) begin
                        o_cmd.start_read = 1'b1;
                        n_state          = S_DIV;
                    end else begin
                        o_cmd.emit_status = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last_step && i_stat.div_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                // buffer read is registered
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_ready) begin
                    o_cmd.emit_digit = 1'b1;
                    n_state          = i_stat.idx_zero ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/rdc_datapath.sv
// value registers, load accumulator, digit divider, digit buffer and output register
module rdc_datapath #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdc_pkg::t_in_item  i_in_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output rdc_pkg::t_out_item o_out_data,
    input  rdc_pkg::t_cmd      i_cmd,
    output rdc_pkg::t_stat     o_stat
);
    import rdc_pkg::*;

    localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CNT_W     = $clog2(MAX_DIGITS);

    logic [VALUE_WIDTH-1:0] r_stored;
    logic [VALUE_WIDTH-1:0] r_pending;
    logic                   r_run_valid;

    logic [PAD_W-1:0]  r_work;
    logic [3:0]        r_rem;
    logic [4:0]        r_base;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_idx;

    logic [3:0] r_mem [MAX_DIGITS];
    logic [3:0] r_rd_data;

    logic      r_out_valid;
    t_out_item r_out_data;

    // load path
    logic [4:0]             w_digit;
    logic                   w_base_ok;
    logic                   w_ok;
    logic [VALUE_WIDTH-1:0] w_prod;
    logic [VALUE_WIDTH-1:0] w_sum;

    assign w_digit   = char_to_digit(i_in_data.char_code);
    assign w_base_ok = (i_in_data.base >= BASE_MIN) && (i_in_data.base <= BASE_MAX);
    assign w_ok      = w_base_ok && (w_digit != DIGIT_NONE)
                       && ({3'b000, w_digit} < i_in_data.base);
    assign w_prod    = r_pending * VALUE_WIDTH'(i_in_data.base);
    assign w_sum     = w_prod + VALUE_WIDTH'(w_ok ? w_digit[3:0] : 4'd0);

    // one divider cycle: DIV_BITS restoring steps on a remainder below the base
    logic [DIV_BITS-1:0] w_q;
    logic [3:0]          w_rem;
    logic [PAD_W-1:0]    w_work;

    always_comb begin
        logic [4:0] v_t;
        logic [3:0] v_rem;
        v_rem = r_rem;
        w_q   = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            v_t = {v_rem, r_work[PAD_W-1-i]};
            if (v_t >= r_base) begin
                v_t              = v_t - r_base;
                w_q[DIV_BITS-1-i] = 1'b1;
            end
            v_rem = v_t[3:0];
        end
        w_rem  = v_rem;
        w_work = (r_work << DIV_BITS) | PAD_W'(w_q);
    end

    logic w_last_step;
    logic w_cnt_full;
    logic w_div_done;

    assign w_last_step = (r_step == STEP_W'(DIV_STEPS - 1));
    assign w_cnt_full  = (r_cnt == CNT_W'(MAX_DIGITS - 1));
    assign w_div_done  = (w_work == '0) || w_cnt_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored    <= '0;
            r_pending   <= '0;
            r_run_valid <= 1'b1;
        end else if (i_cmd.load_digit) begin
            if (i_in_data.last) begin
                if (r_run_valid && w_ok) begin
                    r_stored <= w_sum;
                end
                r_pending   <= '0;
                r_run_valid <= 1'b1;
            end else begin
                r_pending   <= w_sum;
                r_run_valid <= r_run_valid && w_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_read) begin
            r_work <= PAD_W'(r_stored);
            r_rem  <= '0;
            r_base <= i_in_data.base[4:0];
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= w_work;
            if (w_last_step) begin
                r_step <= '0;
                r_rem  <= '0;
                if (w_div_done) begin
                    r_idx <= r_cnt;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else begin
                r_step <= r_step + STEP_W'(1);
                r_rem  <= w_rem;
            end
        end else if (i_cmd.emit_digit && (r_idx != '0)) begin
            r_idx <= r_idx - CNT_W'(1);
        end
    end

    // digit buffer, least significant digit at entry zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && w_last_step) begin
            r_mem[r_cnt] <= w_rem;
        end
        r_rd_data <= r_mem[r_idx];
    end

    logic w_out_ready;
    assign w_out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_status || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_status) begin
            r_out_data.digit_char <= 8'd0;
            r_out_data.accepted   <= (i_in_data.mode == MODE_LOAD) && r_run_valid && w_ok;
            r_out_data.last_res   <= 1'b1;
        end else if (i_cmd.emit_digit) begin
            r_out_data.digit_char <= DIGIT_TABLE[r_rd_data];
            r_out_data.accepted   <= 1'b1;
            r_out_data.last_res   <= (r_idx == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.in_is_read    = (i_in_data.mode == MODE_READ);
    assign o_stat.in_last       = i_in_data.last;
    assign o_stat.in_base_ok    = w_base_ok;
    assign o_stat.div_last_step = w_last_step;
    assign o_stat.div_done      = w_div_done;
    assign o_stat.idx_zero      = (r_idx == '0);
    assign o_stat.out_ready     = w_out_ready;

endmodule

// File: hw/rtl/radix_digit_converter_unit.sv
// Radix digit converter: a load beat carries one ASCII digit (0-9, A-F) and its
// base; digits accumulate as value * base + digit, and the beat marked last
// commits the value when every digit of the run was valid for a base of 2..16,
// returning one beat with the accepted flag. A read beat returns the stored
// value's digits in the given base, most significant first, the final one
// marked last_res; a bad base gives a single rejected beat. The shared divider
// resolves eight quotient bits per cycle, and each digit is then read from the
// digit buffer into a register (S_FETCH) and emitted (S_EMIT). Input is taken
// only while no read is in progress and the output register is free or being
// emptied.
module radix_digit_converter_unit #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rdc_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rdc_pkg::t_out_item o_out_data
);
    import rdc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rdc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// File: hw/rtl/rdc_checker.sv
// port-level checks of the radix digit converter and their bind
`include "radix_digit_converter_unit_defines.svh"

module rdc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input rdc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rdc_pkg::t_out_item o_out_data
);
    import rdc_pkg::*;

    logic                        w_hold;
    logic [$bits(o_out_data):0]  w_out;
    logic                        w_reject;
    logic                        w_reject_ok;
    logic                        w_char_ok;
    logic                        w_read_start;

    assign w_hold       = o_out_valid && i_out_stall;
    assign w_out        = {o_out_valid, o_out_data};
    assign w_reject     = o_out_valid && !o_out_data.accepted;
    assign w_reject_ok  = o_out_data.last_res && (o_out_data.digit_char == 8'd0);
    assign w_char_ok    = (o_out_data.digit_char == 8'd0)
                          || (o_out_data.digit_char >= 8'h30 && o_out_data.digit_char <= 8'h39)
                          || (o_out_data.digit_char >= 8'h41 && o_out_data.digit_char <= 8'h46);
    assign w_read_start = i_in_valid && !o_in_stall && (i_in_data.mode == MODE_READ)
                          && (i_in_data.base >= BASE_MIN) && (i_in_data.base <= BASE_MAX);

    // a stalled result beat stays put
    `RDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_hold, $stable(w_out), "stalled beat changed")

    // rejected beats are single status beats
    `RDC_ASSERT_NOW(a_reject_form, i_clk, i_rst_n, w_reject, w_reject_ok, "bad rejected beat")

    // result characters are zero or an upper-case digit
    `RDC_ASSERT_NOW(a_digit_char, i_clk, i_rst_n, o_out_valid, w_char_ok, "bad digit character")

    // a valid read beat starts the divider and blocks input
    `RDC_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, w_read_start, o_in_stall, "input taken in read")

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (.*);
